[design/rvx_pkg.sv]
`timescale 1ns / 1ps

package rvx_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [4:0]  REG_ZERO    = 5'd0;
  localparam logic [4:0]  REG_A0      = 5'd10;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_REM  = 3'd6;

  localparam logic OPER_EXEC   = 1'b0;
  localparam logic OPER_RETURN = 1'b1;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_B    = 3'd1;
  localparam logic [2:0] SIZE_H    = 3'd2;
  localparam logic [2:0] SIZE_W    = 3'd4;

  localparam logic [1:0] TRAP_NONE    = 2'd0;
  localparam logic [1:0] TRAP_EBREAK  = 2'd1;
  localparam logic [1:0] TRAP_INVALID = 2'd2;

  typedef enum logic [3:0] {
    K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_LOAD, K_STORE, K_ALUI, K_ALU,
    K_MUL, K_DIV, K_REM, K_EBREAK, K_INVALID, K_RETURN
  } kind_t;

  // imm carries the load data for a load return
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] pc;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  access_kind;
    logic [31:0] access_address;
    logic [2:0]  access_size;
    logic [31:0] store_data;
    logic        write_valid;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [1:0]  trap_kind;
    logic [31:0] trap_value;
  } result_t;

  typedef enum logic [1:0] {B_IDLE, B_EXEC, B_DIV, B_DONE} bstate_t;

endpackage

[design/rvx_if.sv]
`timescale 1ns / 1ps

interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [31:0] pc;
  logic [31:0] load_data;
  modport source(output valid, operation, instruction, pc, load_data, input ready);
  modport sink(input valid, operation, instruction, pc, load_data, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  access_kind;
  logic [31:0] access_address;
  logic [2:0]  access_size;
  logic [31:0] store_data;
  logic        write_valid;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic [1:0]  trap_kind;
  logic [31:0] trap_value;
  modport source(output valid, next_pc, access_kind, access_address, access_size, store_data,
                 write_valid, write_index, write_value, trap_kind, trap_value, input ready);
  modport sink(input valid, next_pc, access_kind, access_address, access_size, store_data,
               write_valid, write_index, write_value, trap_kind, trap_value, output ready);
endinterface

[design/rvx_ram.sv]
`timescale 1ns / 1ps

module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem_r[raddr0];
      rdata1 <= mem_r[raddr1];
    end
  end

endmodule

[design/rvx_div.sv]
`timescale 1ns / 1ps

module rvx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[31]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[30:0], ge};
      rem_r <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[design/rvx_front.sv]
`timescale 1ns / 1ps

module rvx_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  rvx_in_if.sink        in_ch,
  output rvx_pkg::dec_t head,
  output logic          head_valid,
  input  logic          pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rvx_pkg::dec_t dec;
  rvx_pkg::dec_t q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic [31:0]   i;
  logic [6:0]    f7;
  logic [31:0]   imm_i;
  logic [31:0]   imm_s;
  logic [31:0]   imm_b;
  logic [31:0]   imm_u;
  logic [31:0]   imm_j;

  always_comb begin
    i     = in_ch.instruction;
    f7    = i[31:25];
    imm_i = {{20{i[31]}}, i[31:20]};
    imm_s = {{20{i[31]}}, i[31:25], i[11:7]};
    imm_b = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
    imm_u = {i[31:12], 12'b0};
    imm_j = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};

    dec.kind = rvx_pkg::K_INVALID;
    dec.f3   = i[14:12];
    dec.alt  = 1'b0;
    dec.rd   = i[11:7];
    dec.rs1  = i[19:15];
    dec.rs2  = i[24:20];
    dec.imm  = imm_i;
    dec.pc   = in_ch.pc;

    if (in_ch.operation == rvx_pkg::OPER_RETURN) begin
      dec.kind = rvx_pkg::K_RETURN;
      dec.imm  = in_ch.load_data;
    end else begin
      unique case (i[6:0])
        rvx_pkg::OPC_LUI: begin
          dec.kind = rvx_pkg::K_LUI;
          dec.imm  = imm_u;
        end
        rvx_pkg::OPC_AUIPC: begin
          dec.kind = rvx_pkg::K_AUIPC;
          dec.imm  = imm_u;
        end
        rvx_pkg::OPC_JAL: begin
          dec.kind = rvx_pkg::K_JAL;
          dec.imm  = imm_j;
        end
        rvx_pkg::OPC_JALR: begin
          if (dec.f3 == rvx_pkg::F3_JALR) dec.kind = rvx_pkg::K_JALR;
        end
        rvx_pkg::OPC_BRANCH: begin
          dec.imm = imm_b;
          unique case (dec.f3)
            rvx_pkg::F3_BEQ, rvx_pkg::F3_BNE, rvx_pkg::F3_BLT, rvx_pkg::F3_BGE,
            rvx_pkg::F3_BGEU: dec.kind = rvx_pkg::K_BRANCH;
            default: dec.kind = rvx_pkg::K_INVALID;
          endcase
        end
        rvx_pkg::OPC_LOAD: begin
          if (dec.f3 == rvx_pkg::F3_LBU || dec.f3 == rvx_pkg::F3_LW) begin
            dec.kind = rvx_pkg::K_LOAD;
          end
        end
        rvx_pkg::OPC_STORE: begin
          dec.imm = imm_s;
          if (dec.f3 == rvx_pkg::F3_SB || dec.f3 == rvx_pkg::F3_SH ||
              dec.f3 == rvx_pkg::F3_SW) begin
            dec.kind = rvx_pkg::K_STORE;
          end
        end
        rvx_pkg::OPC_OPIMM: begin
          unique case (dec.f3)
            rvx_pkg::F3_ADD, rvx_pkg::F3_SLTU, rvx_pkg::F3_XOR,
            rvx_pkg::F3_AND: dec.kind = rvx_pkg::K_ALUI;
            rvx_pkg::F3_SLL: begin
              if (f7 == rvx_pkg::F7_BASE) dec.kind = rvx_pkg::K_ALUI;
            end
            rvx_pkg::F3_SR: begin
              if (f7 == rvx_pkg::F7_BASE || f7 == rvx_pkg::F7_ALT) begin
                dec.kind = rvx_pkg::K_ALUI;
                dec.alt  = i[30];
              end
            end
            default: dec.kind = rvx_pkg::K_INVALID;
          endcase
        end
        rvx_pkg::OPC_OP: begin
          dec.alt = i[30];
          if (f7 == rvx_pkg::F7_BASE) begin
            if (dec.f3 != rvx_pkg::F3_SLT) dec.kind = rvx_pkg::K_ALU;
          end else if (f7 == rvx_pkg::F7_ALT) begin
            if (dec.f3 == rvx_pkg::F3_ADD || dec.f3 == rvx_pkg::F3_SR) begin
              dec.kind = rvx_pkg::K_ALU;
            end
          end else if (f7 == rvx_pkg::F7_MULDIV) begin
            if (dec.f3 == rvx_pkg::F3_MUL) dec.kind = rvx_pkg::K_MUL;
            else if (dec.f3 == rvx_pkg::F3_DIV) dec.kind = rvx_pkg::K_DIV;
            else if (dec.f3 == rvx_pkg::F3_REM) dec.kind = rvx_pkg::K_REM;
          end
        end
        rvx_pkg::OPC_SYSTEM: begin
          if (i == rvx_pkg::EBREAK_WORD) begin
            dec.kind = rvx_pkg::K_EBREAK;
            dec.rs1  = rvx_pkg::REG_A0;
          end
        end
        default: dec.kind = rvx_pkg::K_INVALID;
      endcase
    end
  end

  assign in_ch.ready = (cnt_r != CW'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_r[rd_ptr_r];
  assign head_valid  = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[design/rvx_back.sv]
`timescale 1ns / 1ps

module rvx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rvx_pkg::dec_t head,
  input  logic          head_valid,
  output logic          pop,
  rvx_out_if.source     out_ch
);

  rvx_pkg::bstate_t state_r;
  rvx_pkg::bstate_t state_nxt;
  rvx_pkg::dec_t    item_r;
  rvx_pkg::result_t ex;
  rvx_pkg::result_t wres_r;
  rvx_pkg::result_t out_r;
  logic        out_valid_r;
  logic [31:0] valid_r;
  logic        rv0_r;
  logic        rv1_r;
  logic [31:0] rdata0;
  logic [31:0] rdata1;
  logic [31:0] s1;
  logic [31:0] s2;
  logic [31:0] opb;
  logic [31:0] sum;
  logic [31:0] alu;
  logic [63:0] prod;
  logic [31:0] pc4;
  logic        take;
  logic        is_div;
  logic        exec_en;
  logic        fin;
  logic        rf_we;
  logic        load_pending_r;
  logic [4:0]  load_dst_r;
  logic        load_byte_r;
  logic        div_done;
  logic [31:0] quo;
  logic [31:0] rem;
  logic        neg_q_r;
  logic        neg_r_r;
  logic        bzero_r;
  logic [31:0] a_r;
  logic [31:0] div_res;
  logic [31:0] load_val;

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (wres_r.write_index),
    .wdata  (wres_r.write_value),
    .re     (pop),
    .raddr0 (head.rs1),
    .raddr1 (head.rs2),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // registers never written read as zero
  assign s1     = rv0_r ? rdata0 : '0;
  assign s2     = rv1_r ? rdata1 : '0;
  assign is_div = (item_r.kind == rvx_pkg::K_DIV) || (item_r.kind == rvx_pkg::K_REM);

  rvx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (exec_en && is_div),
    .dividend  (s1[31] ? 32'd0 - s1 : s1),
    .divisor   (s2[31] ? 32'd0 - s2 : s2),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvx_pkg::B_IDLE: if (head_valid) state_nxt = rvx_pkg::B_EXEC;
      rvx_pkg::B_EXEC: state_nxt = is_div ? rvx_pkg::B_DIV : rvx_pkg::B_DONE;
      rvx_pkg::B_DIV:  if (div_done) state_nxt = rvx_pkg::B_DONE;
      rvx_pkg::B_DONE: if (!out_valid_r || out_ch.ready) state_nxt = rvx_pkg::B_IDLE;
      default:         state_nxt = rvx_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state_r == rvx_pkg::B_IDLE) && head_valid;
    exec_en = (state_r == rvx_pkg::B_EXEC);
    fin     = (state_r == rvx_pkg::B_DONE) && (!out_valid_r || out_ch.ready);
    rf_we   = fin && wres_r.write_valid;
  end

  always_comb begin
    opb  = (item_r.kind == rvx_pkg::K_ALU) ? s2 : item_r.imm;
    sum  = s1 + opb;
    prod = s1 * s2;
    pc4  = item_r.pc + 32'd4;
    case (item_r.f3)
      rvx_pkg::F3_ADD:  alu = item_r.alt ? s1 - opb : sum;
      rvx_pkg::F3_SLL:  alu = s1 << opb[4:0];
      rvx_pkg::F3_SLTU: alu = {31'd0, s1 < opb};
      rvx_pkg::F3_XOR:  alu = s1 ^ opb;
      rvx_pkg::F3_SR:   alu = item_r.alt ? 32'($signed(s1) >>> opb[4:0]) : s1 >> opb[4:0];
      rvx_pkg::F3_OR:   alu = s1 | opb;
      rvx_pkg::F3_AND:  alu = s1 & opb;
      default:          alu = '0;
    endcase
    case (item_r.f3)
      rvx_pkg::F3_BEQ:  take = (s1 == s2);
      rvx_pkg::F3_BNE:  take = (s1 != s2);
      rvx_pkg::F3_BLT:  take = ($signed(s1) < $signed(s2));
      rvx_pkg::F3_BGE:  take = ($signed(s1) >= $signed(s2));
      rvx_pkg::F3_BGEU: take = (s1 >= s2);
      default:          take = 1'b0;
    endcase
    load_val = load_byte_r ? {24'd0, item_r.imm[7:0]} : item_r.imm;

    ex             = '0;
    ex.next_pc     = pc4;
    ex.write_index = item_r.rd;
    unique case (item_r.kind)
      rvx_pkg::K_LUI:   ex.write_value = item_r.imm;
      rvx_pkg::K_AUIPC: ex.write_value = item_r.pc + item_r.imm;
      rvx_pkg::K_JAL: begin
        ex.write_value = pc4;
        ex.next_pc     = item_r.pc + item_r.imm;
      end
      rvx_pkg::K_JALR: begin
        ex.write_value = pc4;
        ex.next_pc     = {sum[31:1], 1'b0};
      end
      rvx_pkg::K_BRANCH: if (take) ex.next_pc = item_r.pc + item_r.imm;
      rvx_pkg::K_LOAD: begin
        ex.access_kind    = rvx_pkg::ACC_READ;
        ex.access_address = sum;
        ex.access_size    = (item_r.f3 == rvx_pkg::F3_LBU) ? rvx_pkg::SIZE_B : rvx_pkg::SIZE_W;
      end
      rvx_pkg::K_STORE: begin
        ex.access_kind    = rvx_pkg::ACC_WRITE;
        ex.access_address = s1 + item_r.imm;
        ex.store_data     = s2;
        case (item_r.f3)
          rvx_pkg::F3_SB: ex.access_size = rvx_pkg::SIZE_B;
          rvx_pkg::F3_SH: ex.access_size = rvx_pkg::SIZE_H;
          default:        ex.access_size = rvx_pkg::SIZE_W;
        endcase
      end
      rvx_pkg::K_ALUI, rvx_pkg::K_ALU: ex.write_value = alu;
      rvx_pkg::K_MUL: ex.write_value = prod[31:0];
      rvx_pkg::K_DIV, rvx_pkg::K_REM: ex.write_value = '0;
      rvx_pkg::K_EBREAK: begin
        ex.trap_kind  = rvx_pkg::TRAP_EBREAK;
        ex.trap_value = s1;
      end
      rvx_pkg::K_INVALID: ex.trap_kind = rvx_pkg::TRAP_INVALID;
      rvx_pkg::K_RETURN: begin
        ex.next_pc     = '0;
        ex.write_index = load_dst_r;
        ex.write_value = load_val;
      end
      default: ex.trap_kind = rvx_pkg::TRAP_INVALID;
    endcase

    // which kinds write a register at all
    case (item_r.kind)
      rvx_pkg::K_LUI, rvx_pkg::K_AUIPC, rvx_pkg::K_JAL, rvx_pkg::K_JALR, rvx_pkg::K_ALUI,
      rvx_pkg::K_ALU, rvx_pkg::K_MUL, rvx_pkg::K_DIV, rvx_pkg::K_REM:
        ex.write_valid = (item_r.rd != rvx_pkg::REG_ZERO);
      rvx_pkg::K_RETURN:
        ex.write_valid = load_pending_r && (load_dst_r != rvx_pkg::REG_ZERO);
      default:
        ex.write_valid = 1'b0;
    endcase
    if (!ex.write_valid) begin
      ex.write_index = '0;
      ex.write_value = '0;
    end

    if (item_r.kind == rvx_pkg::K_DIV) begin
      div_res = bzero_r ? '1 : (neg_q_r ? 32'd0 - quo : quo);
    end else begin
      div_res = bzero_r ? a_r : (neg_r_r ? 32'd0 - rem : rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= rvx_pkg::B_IDLE;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      load_pending_r <= 1'b0;
      load_dst_r     <= '0;
      load_byte_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) begin
        valid_r[wres_r.write_index] <= 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (exec_en && item_r.kind == rvx_pkg::K_LOAD) begin
        load_pending_r <= 1'b1;
        load_dst_r     <= item_r.rd;
        load_byte_r    <= (item_r.f3 == rvx_pkg::F3_LBU);
      end else if (exec_en && item_r.kind == rvx_pkg::K_RETURN) begin
        load_pending_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
      rv0_r  <= valid_r[head.rs1];
      rv1_r  <= valid_r[head.rs2];
    end
    if (exec_en) begin
      wres_r  <= ex;
      neg_q_r <= s1[31] ^ s2[31];
      neg_r_r <= s1[31];
      bzero_r <= (s2 == '0);
      a_r     <= s1;
    end else if (div_done && wres_r.write_valid) begin
      wres_r.write_value <= div_res;
    end
    if (fin) begin
      out_r <= wres_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.next_pc        = out_r.next_pc;
  assign out_ch.access_kind    = out_r.access_kind;
  assign out_ch.access_address = out_r.access_address;
  assign out_ch.access_size    = out_r.access_size;
  assign out_ch.store_data     = out_r.store_data;
  assign out_ch.write_valid    = out_r.write_valid;
  assign out_ch.write_index    = out_r.write_index;
  assign out_ch.write_value    = out_r.write_value;
  assign out_ch.trap_kind      = out_r.trap_kind;
  assign out_ch.trap_value     = out_r.trap_value;

endmodule

[design/rv32im_subset_execute_unit.sv]
`timescale 1ns / 1ps

// RV32IM subset execute unit.
// in_ch carries one request per instruction (operation 0: instruction and pc) or per
// returned load (operation 1: load_data). out_ch carries exactly one result per request:
// next pc, memory access, register write and trap report, in request order.
// A decoder in front classifies each request into a queue of QUEUE_DEPTH entries; in_ch
// is ready whenever the queue has room, so requests are taken while work is in flight.
// The execute side takes one request at a time through a register file read step, an
// execute step and a writeback step; div and rem also go through a one-bit-per-cycle
// divider between the execute and writeback steps.
// The result sits in an output register; while out_ch.ready is low the next result waits
// in writeback and the queue fills, after which in_ch.ready drops.
// Reset (synchronous, active low) empties the queue, drops out_ch.valid, clears the
// pending load and marks every register as zero; no clearing pass is needed.
module rv32im_subset_execute_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst_n,
  rvx_in_if.sink    in_ch,
  rvx_out_if.source out_ch
);

  rvx_pkg::dec_t head;
  logic          head_valid;
  logic          pop;

  rvx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  rvx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[design/rvx_checker.sv]
`timescale 1ns / 1ps

module rvx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_access_kind,
  input logic [31:0] out_access_address,
  input logic [2:0]  out_access_size,
  input logic [31:0] out_store_data,
  input logic        out_write_valid,
  input logic [4:0]  out_write_index,
  input logic [31:0] out_write_value,
  input logic [1:0]  out_trap_kind
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_value) &&
      $stable(out_access_address))
    else $error("result changed while stalled");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_write_index != rvx_pkg::REG_ZERO)
    else $error("write to x0 reported");

  a_trap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trap_kind != rvx_pkg::TRAP_NONE |->
      !out_write_valid && out_access_kind == rvx_pkg::ACC_NONE)
    else $error("trap with side effects");

  a_no_access_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_kind == rvx_pkg::ACC_NONE |->
      out_access_size == rvx_pkg::SIZE_NONE && out_access_address == '0 &&
      out_store_data == '0)
    else $error("access fields set without access");

endmodule

bind rv32im_subset_execute_unit rvx_checker u_rvx_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_access_kind    (out_ch.access_kind),
  .out_access_address (out_ch.access_address),
  .out_access_size    (out_ch.access_size),
  .out_store_data     (out_ch.store_data),
  .out_write_valid    (out_ch.write_valid),
  .out_write_index    (out_ch.write_index),
  .out_write_value    (out_ch.write_value),
  .out_trap_kind      (out_ch.trap_kind)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  logic clk;
  logic rst_n;
  rvx_in_if  in_ch();
  rvx_out_if out_ch();

  rv32im_subset_execute_unit u_dut(.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  typedef struct {
    logic        oper;
    logic [31:0] insn;
    logic [31:0] pc;
    logic [31:0] ldata;
  } request_t;

  typedef struct {
    request_t         req;
    logic             has_exp;
    rvx_pkg::result_t exp;
  } row_t;

  // predictor state
  logic [31:0] regs[32];
  logic        ld_pending;
  logic [4:0]  ld_dest;
  logic        ld_byte;

  rvx_pkg::result_t expected_q[$];
  request_t req_q[$];
  int      n_err;
  int      n_sent;
  longint  cycles;
  bit      stim_done;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_err++;
    $display("tb: mismatch %s got %h want %h", what, got, want);
  endtask

  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
    if (b == 0) return 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [31:0] srem(input logic [31:0] a, input logic [31:0] b);
    if (b == 0) return a;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 0;
    return $signed(a) % $signed(b);
  endfunction

  function automatic rvx_pkg::result_t execute_insn(input request_t r);
    rvx_pkg::result_t o;
    logic [31:0] insn, s1, s2, immi, imms, immb, immj, res;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd;
    logic wr;
    logic take;
    logic [31:0] d;
    insn = r.insn;
    o = '0;
    wr = 1'b0;
    res = 0;
    take = 1'b0;
    opc = insn[6:0];
    f3 = insn[14:12];
    f7 = insn[31:25];
    rd = insn[11:7];
    s1 = regs[insn[19:15]];
    s2 = regs[insn[24:20]];
    immi = {{20{insn[31]}}, insn[31:20]};
    imms = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    immb = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    immj = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    o.next_pc = r.pc + 32'd4;
    if (r.oper == rvx_pkg::OPER_RETURN) begin
      o.next_pc = 0;
      if (ld_pending) begin
        d = ld_byte ? {24'd0, r.ldata[7:0]} : r.ldata;
        if (ld_dest != rvx_pkg::REG_ZERO) begin
          regs[ld_dest] = d;
          o.write_valid = 1;
          o.write_index = ld_dest;
          o.write_value = d;
        end
        ld_pending = 0;
      end
      return o;
    end
    case (opc)
      rvx_pkg::OPC_LUI: begin res = {insn[31:12], 12'd0}; wr = 1; end
      rvx_pkg::OPC_AUIPC: begin res = r.pc + {insn[31:12], 12'd0}; wr = 1; end
      rvx_pkg::OPC_JAL: begin res = r.pc + 32'd4; wr = 1; o.next_pc = r.pc + immj; end
      rvx_pkg::OPC_JALR:
        if (f3 == rvx_pkg::F3_JALR) begin
          res = r.pc + 32'd4; wr = 1; o.next_pc = (s1 + immi) & ~32'd1;
        end else o.trap_kind = rvx_pkg::TRAP_INVALID;
      rvx_pkg::OPC_BRANCH: begin
        case (f3)
          rvx_pkg::F3_BEQ: take = s1 == s2;
          rvx_pkg::F3_BNE: take = s1 != s2;
          rvx_pkg::F3_BLT: take = $signed(s1) < $signed(s2);
          rvx_pkg::F3_BGE: take = $signed(s1) >= $signed(s2);
          rvx_pkg::F3_BGEU: take = s1 >= s2;
          default: o.trap_kind = rvx_pkg::TRAP_INVALID;
        endcase
        if (take) o.next_pc = r.pc + immb;
      end
      rvx_pkg::OPC_LOAD:
        if (f3 == rvx_pkg::F3_LBU || f3 == rvx_pkg::F3_LW) begin
          o.access_kind = rvx_pkg::ACC_READ;
          o.access_address = s1 + immi;
          o.access_size = (f3 == rvx_pkg::F3_LBU) ? rvx_pkg::SIZE_B : rvx_pkg::SIZE_W;
          ld_pending = 1; ld_dest = rd; ld_byte = (f3 == rvx_pkg::F3_LBU);
        end else o.trap_kind = rvx_pkg::TRAP_INVALID;
      rvx_pkg::OPC_STORE:
        if (f3 <= rvx_pkg::F3_SW) begin
          o.access_kind = rvx_pkg::ACC_WRITE;
          o.access_address = s1 + imms;
          o.access_size = (f3 == rvx_pkg::F3_SB) ? rvx_pkg::SIZE_B :
                          (f3 == rvx_pkg::F3_SH) ? rvx_pkg::SIZE_H : rvx_pkg::SIZE_W;
          o.store_data = s2;
        end else o.trap_kind = rvx_pkg::TRAP_INVALID;
      rvx_pkg::OPC_OPIMM: begin
        wr = 1;
        case (f3)
          rvx_pkg::F3_ADD: res = s1 + immi;
          rvx_pkg::F3_SLTU: res = (s1 < immi) ? 1 : 0;
          rvx_pkg::F3_XOR: res = s1 ^ immi;
          rvx_pkg::F3_AND: res = s1 & immi;
          rvx_pkg::F3_SLL:
            if (f7 == rvx_pkg::F7_BASE) res = s1 << immi[4:0];
            else begin wr = 0; o.trap_kind = rvx_pkg::TRAP_INVALID; end
          rvx_pkg::F3_SR:
            if (f7 == rvx_pkg::F7_BASE) res = s1 >> immi[4:0];
            else if (f7 == rvx_pkg::F7_ALT) res = $signed(s1) >>> immi[4:0];
            else begin wr = 0; o.trap_kind = rvx_pkg::TRAP_INVALID; end
          default: begin wr = 0; o.trap_kind = rvx_pkg::TRAP_INVALID; end
        endcase
      end
      rvx_pkg::OPC_OP: begin
        wr = 1;
        if (f7 == rvx_pkg::F7_BASE) begin
          case (f3)
            rvx_pkg::F3_ADD: res = s1 + s2;
            rvx_pkg::F3_SLL: res = s1 << s2[4:0];
            rvx_pkg::F3_SLTU: res = (s1 < s2) ? 1 : 0;
            rvx_pkg::F3_XOR: res = s1 ^ s2;
            rvx_pkg::F3_SR: res = s1 >> s2[4:0];
            rvx_pkg::F3_OR: res = s1 | s2;
            rvx_pkg::F3_AND: res = s1 & s2;
            default: begin wr = 0; o.trap_kind = rvx_pkg::TRAP_INVALID; end
          endcase
        end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) res = s1 - s2;
        else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_SR) res = $signed(s1) >>> s2[4:0];
        else if (f7 == rvx_pkg::F7_MULDIV && f3 == rvx_pkg::F3_MUL) res = s1 * s2;
        else if (f7 == rvx_pkg::F7_MULDIV && f3 == rvx_pkg::F3_DIV) res = sdiv(s1, s2);
        else if (f7 == rvx_pkg::F7_MULDIV && f3 == rvx_pkg::F3_REM) res = srem(s1, s2);
        else begin wr = 0; o.trap_kind = rvx_pkg::TRAP_INVALID; end
      end
      rvx_pkg::OPC_SYSTEM:
        if (insn == rvx_pkg::EBREAK_WORD) begin
          o.trap_kind = rvx_pkg::TRAP_EBREAK; o.trap_value = regs[rvx_pkg::REG_A0];
        end else o.trap_kind = rvx_pkg::TRAP_INVALID;
      default: o.trap_kind = rvx_pkg::TRAP_INVALID;
    endcase
    if (wr && rd != rvx_pkg::REG_ZERO) begin
      regs[rd] = res;
      o.write_valid = 1; o.write_index = rd; o.write_value = res;
    end
    regs[0] = 0;
    return o;
  endfunction

  function automatic request_t mk_exec(input logic [31:0] insn, input logic [31:0] pc);
    request_t r;
    r.oper = rvx_pkg::OPER_EXEC; r.insn = insn; r.pc = pc; r.ldata = $urandom;
    return r;
  endfunction

  function automatic request_t mk_ret(input logic [31:0] data);
    request_t r;
    r.oper = rvx_pkg::OPER_RETURN; r.insn = $urandom; r.pc = $urandom; r.ldata = data;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OPC_BRANCH};
  endfunction

  // instruction with random fields (some invalid), small register pool for dependencies
  function automatic logic [31:0] rand_insn();
    logic [4:0] rd, rs1, rs2;
    logic [11:0] imm;
    logic [2:0] f3s[7];
    rd = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 12));
    rs1 = 5'($urandom_range(0, 12));
    rs2 = 5'($urandom_range(0, 12));
    imm = 12'($urandom);
    f3s = '{rvx_pkg::F3_ADD, rvx_pkg::F3_SLL, rvx_pkg::F3_SLTU, rvx_pkg::F3_XOR,
            rvx_pkg::F3_SR, rvx_pkg::F3_OR, rvx_pkg::F3_AND};
    case ($urandom_range(0, 17))
      0: return {20'($urandom_range(0, 32'hFFFFF)), rd, rvx_pkg::OPC_LUI};
      1: return {20'($urandom_range(0, 32'hFFFFF)), rd, rvx_pkg::OPC_AUIPC};
      2: return {20'($urandom_range(0, 32'hFFFFF)), rd, rvx_pkg::OPC_JAL};
      3: return enc_i(imm, rs1, rvx_pkg::F3_JALR, rd, rvx_pkg::OPC_JALR);
      4, 5: return enc_b({imm, 1'b0}, rs2, rs1, 3'($urandom_range(0, 7)));
      6: return enc_i(imm, rs1, $urandom_range(0, 1) ? rvx_pkg::F3_LW : rvx_pkg::F3_LBU, rd,
                      rvx_pkg::OPC_LOAD);
      7: return enc_s(imm, rs2, rs1, 3'($urandom_range(0, 2)));
      8, 9: return enc_i(imm, rs1, 3'($urandom_range(0, 7)), rd, rvx_pkg::OPC_OPIMM);
      10: return enc_i({$urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE, imm[4:0]},
                       rs1, rvx_pkg::F3_SR, rd, rvx_pkg::OPC_OPIMM);
      11, 12: return enc_r(rvx_pkg::F7_BASE, rs2, rs1, f3s[$urandom_range(0, 6)], rd);
      13: return enc_r(rvx_pkg::F7_ALT, rs2, rs1,
                       $urandom_range(0, 1) ? rvx_pkg::F3_ADD : rvx_pkg::F3_SR, rd);
      14: return enc_r(rvx_pkg::F7_MULDIV, rs2, rs1, rvx_pkg::F3_MUL, rd);
      15: return enc_r(rvx_pkg::F7_MULDIV, rs2, rs1,
                       $urandom_range(0, 1) ? rvx_pkg::F3_DIV : rvx_pkg::F3_REM, rd);
      16: return rvx_pkg::EBREAK_WORD;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // request driver
  initial begin
    row_t rows[$];
    row_t rw;
    request_t r;
    int gap;
    in_ch.valid = 0; in_ch.operation = 0; in_ch.instruction = 0;
    in_ch.pc = 0; in_ch.load_data = 0;
    rst_n = 0;
    stim_done = 0;
    foreach (regs[i]) regs[i] = 0;
    ld_pending = 0; ld_dest = 0; ld_byte = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed rows; has_exp marks results fixed by hand
    rw.has_exp = 1;
    rw.req = mk_ret(32'hFFFF_FFFF);  // return with nothing pending
    rw.exp = '0; rows.push_back(rw);
    rw.req = mk_exec(rvx_pkg::EBREAK_WORD, 32'hFFFF_FFFC);
    rw.exp = '0; rw.exp.trap_kind = rvx_pkg::TRAP_EBREAK; rows.push_back(rw);
    rw.req = mk_exec(32'hFFFF_FFFF, 32'h0);
    rw.exp = '0; rw.exp.next_pc = 32'd4; rw.exp.trap_kind = rvx_pkg::TRAP_INVALID;
    rows.push_back(rw);
    rw.req = mk_exec(32'h0000_0000, 32'h100);
    rw.exp = '0; rw.exp.next_pc = 32'h104; rw.exp.trap_kind = rvx_pkg::TRAP_INVALID;
    rows.push_back(rw);
    rw.req = mk_exec({20'hFFFFF, 5'd1, rvx_pkg::OPC_LUI}, 32'h0);
    rw.exp = '0; rw.exp.next_pc = 32'd4; rw.exp.write_valid = 1'b1; rw.exp.write_index = 5'd1;
    rw.exp.write_value = 32'hFFFF_F000; rows.push_back(rw);
    rw.has_exp = 0;
    rw.req = mk_exec(enc_i(12'h7FF, 5'd0, rvx_pkg::F3_ADD, 5'd2, rvx_pkg::OPC_OPIMM), 32'h8);
    rows.push_back(rw);
    rw.req = mk_exec({20'h80000, 5'd3, rvx_pkg::OPC_LUI}, 32'hC); rows.push_back(rw);
    rw.req = mk_exec(enc_i(12'hFFF, 5'd0, rvx_pkg::F3_ADD, 5'd4, rvx_pkg::OPC_OPIMM), 32'h10);
    rows.push_back(rw);
    rw.req = mk_exec(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd3, rvx_pkg::F3_DIV, 5'd5), 32'h14);
    rows.push_back(rw);
    rw.req = mk_exec(enc_r(rvx_pkg::F7_MULDIV, 5'd0, 5'd3, rvx_pkg::F3_REM, 5'd6), 32'h18);
    rows.push_back(rw);
    rw.req = mk_exec(enc_r(rvx_pkg::F7_MULDIV, 5'd4, 5'd3, rvx_pkg::F3_DIV, 5'd7), 32'h1C);
    rows.push_back(rw);
    rw.req = mk_exec(enc_r(rvx_pkg::F7_MULDIV, 5'd4, 5'd3, rvx_pkg::F3_REM, 5'd8), 32'h20);
    rows.push_back(rw);
    rw.req = mk_exec(enc_r(rvx_pkg::F7_MULDIV, 5'd3, 5'd3, rvx_pkg::F3_MUL, 5'd0), 32'h24);
    rows.push_back(rw);
    rw.req = mk_exec(enc_i(12'h401, 5'd3, rvx_pkg::F3_SR, 5'd9, rvx_pkg::OPC_OPIMM), 32'h28);
    rows.push_back(rw);
    rw.req = mk_exec(enc_i(12'h001, 5'd1, rvx_pkg::F3_LBU, 5'd10, rvx_pkg::OPC_LOAD), 32'h2C);
    rows.push_back(rw);
    rw.req = mk_exec(enc_s(12'h800, 5'd1, 5'd3, rvx_pkg::F3_SH), 32'h30); rows.push_back(rw);
    rw.req = mk_ret(32'hA5A5_A5A5); rows.push_back(rw);
    rw.req = mk_exec(rvx_pkg::EBREAK_WORD, 32'h34); rows.push_back(rw);
    rw.req = mk_exec(enc_i(12'h0, 5'd3, rvx_pkg::F3_LW, 5'd0, rvx_pkg::OPC_LOAD), 32'h38);
    rows.push_back(rw);
    rw.req = mk_ret(32'h1234_5678); rows.push_back(rw);
    rw.req = mk_exec(enc_b(13'h1000, 5'd4, 5'd3, rvx_pkg::F3_BLT), 32'h3C); rows.push_back(rw);
    rw.req = mk_exec(enc_b(13'h0FFE, 5'd4, 5'd3, rvx_pkg::F3_BGEU), 32'hFFFF_FFF0);
    rows.push_back(rw);
    rw.req = mk_exec({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd11, rvx_pkg::OPC_JAL}, 32'h0);
    rows.push_back(rw);
    rw.req = mk_exec(enc_i(12'hFFF, 5'd4, rvx_pkg::F3_JALR, 5'd12, rvx_pkg::OPC_JALR), 32'h40);
    rows.push_back(rw);
    rw.req = mk_exec({20'hFFFFF, 5'd13, rvx_pkg::OPC_AUIPC}, 32'hFFFF_FFFF); rows.push_back(rw);

    for (int i = 0; i < rows.size() + 800; i++) begin
      if (i < rows.size()) r = rows[i].req;
      else if ($urandom_range(0, 5) == 0) r = mk_ret($urandom);
      else r = mk_exec(rand_insn(), $urandom_range(0, 3) == 0 ? $urandom
                       : {30'($urandom_range(0, 255)), 2'b00});
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1;
      in_ch.operation <= r.oper;
      in_ch.instruction <= r.insn;
      in_ch.pc <= r.pc;
      in_ch.load_data <= r.ldata;
      do @(posedge clk); while (!in_ch.ready);
      // predicted in order of acceptance
      if (i < rows.size() && rows[i].has_exp) begin
        void'(execute_insn(r));
        expected_q.push_back(rows[i].exp);
      end else expected_q.push_back(execute_insn(r));
      n_sent++;
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // result sink
  initial begin
    int stall;
    rvx_pkg::result_t w, g;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      g.next_pc = out_ch.next_pc; g.access_kind = out_ch.access_kind;
      g.access_address = out_ch.access_address; g.access_size = out_ch.access_size;
      g.store_data = out_ch.store_data; g.write_valid = out_ch.write_valid;
      g.write_index = out_ch.write_index; g.write_value = out_ch.write_value;
      g.trap_kind = out_ch.trap_kind; g.trap_value = out_ch.trap_value;
      if (expected_q.size() == 0) begin
        report("unexpected result", g.next_pc, 0);
      end else begin
        w = expected_q.pop_front();
        if (g.next_pc !== w.next_pc) report("next_pc", g.next_pc, w.next_pc);
        if (g.access_kind !== w.access_kind) report("access_kind", g.access_kind, w.access_kind);
        if (g.access_address !== w.access_address)
          report("access_address", g.access_address, w.access_address);
        if (g.access_size !== w.access_size) report("access_size", g.access_size, w.access_size);
        if (g.store_data !== w.store_data) report("store_data", g.store_data, w.store_data);
        if (g.write_valid !== w.write_valid) report("write_valid", g.write_valid, w.write_valid);
        if (g.write_index !== w.write_index) report("write_index", g.write_index, w.write_index);
        if (g.write_value !== w.write_value) report("write_value", g.write_value, w.write_value);
        if (g.trap_kind !== w.trap_kind) report("trap_kind", g.trap_kind, w.trap_kind);
        if (g.trap_value !== w.trap_value) report("trap_value", g.trap_value, w.trap_value);
      end
    end
  end

  // end of run and watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (stim_done && expected_q.size() == 0) begin
        repeat (60) @(posedge clk);
        if (n_err == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
      end
      if (cycles > 200000) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

endmodule
